[src/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mbrtu_pkg: shared types and constants for the modbus rtu frame decoder
// byte and record payload types, error and role codes, crc helper
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int HeaderBytes = 8;
  localparam int LengthBits  = 10;
  localparam int QueueDepth  = 2;

  typedef logic [LengthBits-1:0] len_t;

  typedef enum logic [1:0] {
    ROLE_REQUEST   = 2'd0,
    ROLE_RESPONSE  = 2'd1,
    ROLE_EXCEPTION = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    CRC_UNCHECKED = 2'd0,
    CRC_VALID     = 2'd1,
    CRC_INVALID   = 2'd2
  } crc_st_t;

  typedef enum logic [3:0] {
    ERR_OK              = 4'd0,
    ERR_SHORT           = 4'd1,
    ERR_UNSUPPORTED_FC  = 4'd2,
    ERR_TRUNCATED       = 4'd3,
    ERR_CRC             = 4'd4,
    ERR_EXC_LEN         = 4'd5,
    ERR_READ_REQ_LEN    = 4'd6,
    ERR_READ_RESP_TRUNC = 4'd7,
    ERR_READ_COUNT      = 4'd8,
    ERR_SINGLE_LEN      = 4'd9,
    ERR_MULTI_REQ_TRUNC = 4'd10,
    ERR_MULTI_COUNT     = 4'd11,
    ERR_MULTI_RESP_LEN  = 4'd12
  } err_t;

  typedef enum logic [2:0] {
    FS_NONE      = 3'd0,
    FS_START_QTY = 3'd1,
    FS_ADDR_VAL  = 3'd2,
    FS_COUNT     = 3'd3,
    FS_START_QTY_COUNT = 3'd4
  } fset_t;

  localparam logic [6:0] FcMask        = 7'h7F;
  localparam logic [7:0] ExcBit        = 8'h80;
  localparam logic [6:0] FcReadCoils   = 7'h01;
  localparam logic [6:0] FcReadInput   = 7'h04;
  localparam logic [6:0] FcWriteCoil   = 7'h05;
  localparam logic [6:0] FcWriteReg    = 7'h06;
  localparam logic [6:0] FcWriteCoils  = 7'h0F;
  localparam logic [6:0] FcWriteRegs   = 7'h10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       from_master;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  station;
    logic [6:0]  function_code;
    logic [1:0]  frame_role;
    logic [7:0]  exception_code;
    logic [15:0] start_address;
    logic [15:0] count_or_value;
    logic [7:0]  byte_count;
    logic [1:0]  crc_status;
    logic [3:0]  error_code;
    logic [2:0]  field_set;
  } rec_t;

  // snapshot of a finished frame handed from front to back
  typedef struct packed {
    logic [HeaderBytes-1:0][7:0] hdr;
    logic [15:0] pcrc;
    logic [15:0] rx_crc;
    len_t        len;
    logic        master;
  } frame_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/mbrtu_if.sv]
// ----------------------------------------------------------------------------
// mbrtu_in_if / mbrtu_out_if: valid-ready channels of the decoder
// input byte channel and output decode record channel
// ----------------------------------------------------------------------------
interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       from_master;
  modport source (output valid, data_byte, last_byte, from_master, input ready);
  modport sink (input valid, data_byte, last_byte, from_master, output ready);
endinterface

interface mbrtu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  station;
  logic [6:0]  function_code;
  logic [1:0]  frame_role;
  logic [7:0]  exception_code;
  logic [15:0] start_address;
  logic [15:0] count_or_value;
  logic [7:0]  byte_count;
  logic [1:0]  crc_status;
  logic [3:0]  error_code;
  logic [2:0]  field_set;
  modport source (output valid, station, function_code, frame_role, exception_code,
                  start_address, count_or_value, byte_count, crc_status, error_code,
                  field_set, input ready);
  modport sink (input valid, station, function_code, frame_role, exception_code,
                start_address, count_or_value, byte_count, crc_status, error_code,
                field_set, output ready);
endinterface

[src/mbrtu_front.sv]
// ----------------------------------------------------------------------------
// mbrtu_front: byte collector
// counts bytes, keeps header and tail, runs the lagging payload crc and
// pushes a frame snapshot on the last byte
// ----------------------------------------------------------------------------
module mbrtu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbrtu_pkg::in_item_t in_item,
  output logic              push,
  output mbrtu_pkg::frame_t push_frame,
  input  logic              q_full
);
  import mbrtu_pkg::*;

  len_t                        len;
  logic [15:0]                 pcrc;
  logic [HeaderBytes-1:0][7:0] hdr;
  logic [1:0][7:0]             tail;

  len_t                        len_next;
  logic [15:0]                 pcrc_next;
  logic [HeaderBytes-1:0][7:0] hdr_next;
  logic                        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    pcrc_next = (len >= len_t'(2)) ? crc16_byte(pcrc, tail[0]) : pcrc;
    hdr_next  = hdr;
    if (len < len_t'(HeaderBytes)) begin
      hdr_next[len[$clog2(HeaderBytes)-1:0]] = in_item.data_byte;
    end
    len_next = (len != {LengthBits{1'b1}}) ? len + len_t'(1) : len;
  end

  always_comb begin
    push              = acc && in_item.last_byte;
    push_frame.hdr    = hdr_next;
    push_frame.pcrc   = pcrc_next;
    push_frame.rx_crc = {in_item.data_byte, tail[1]};
    push_frame.len    = len_next;
    push_frame.master = in_item.from_master;
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && in_item.last_byte)) begin
      len  <= '0;
      pcrc <= 16'hFFFF;
      hdr  <= '0;
      tail <= '0;
    end else if (acc) begin
      len     <= len_next;
      pcrc    <= pcrc_next;
      hdr     <= hdr_next;
      tail[0] <= tail[1];
      tail[1] <= in_item.data_byte;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) push |=> (len == '0))
    else $error("collector not cleared after last byte");
  assert property (@(posedge clk) disable iff (rst)
    (acc && !in_item.last_byte && len == {LengthBits{1'b1}}) |=> (len == {LengthBits{1'b1}}))
    else $error("length count wrapped");
endmodule

[src/mbrtu_queue.sv]
// ----------------------------------------------------------------------------
// mbrtu_queue: short frame queue
// two entry fifo between collector and decoder
// ----------------------------------------------------------------------------
module mbrtu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mbrtu_pkg::frame_t push_frame,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output mbrtu_pkg::frame_t head
);
  import mbrtu_pkg::*;

  frame_t                        mem [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_ptr;
  logic [$clog2(QueueDepth)-1:0] rd_ptr;
  logic [$clog2(QueueDepth):0]   fill;

  assign full      = (fill == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) fill <= ($clog2(QueueDepth)+1)'(QueueDepth))
    else $error("queue overfill");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> not_empty) else $error("push lost");
endmodule

[src/mbrtu_back.sv]
// ----------------------------------------------------------------------------
// mbrtu_back: frame decoder
// classifies a queued frame and registers the decode record
// ----------------------------------------------------------------------------
module mbrtu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  mbrtu_pkg::frame_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mbrtu_pkg::rec_t   rec
);
  import mbrtu_pkg::*;

  rec_t        r;
  len_t        n;
  len_t        p;
  logic [6:0]  fc;
  logic [15:0] w2;
  logic [15:0] w4;
  logic        rq;
  logic        rs;

  always_comb begin
    n  = head.len;
    p  = (n >= len_t'(2)) ? n - len_t'(2) : '0;
    fc = head.hdr[1][6:0] & FcMask;
    w2 = {head.hdr[2], head.hdr[3]};
    w4 = {head.hdr[4], head.hdr[5]};
    rq = 1'b0;
    rs = 1'b0;
    r  = '0;
    r.station       = head.hdr[0];
    r.function_code = fc;
    r.frame_role    = ROLE_REQUEST;
    r.crc_status    = CRC_UNCHECKED;
    r.error_code    = ERR_OK;
    r.field_set     = FS_NONE;
    if (n < len_t'(2)) begin
      r.error_code = ERR_SHORT;
    end else if (!((fc >= FcReadCoils && fc <= FcWriteReg) || fc == FcWriteCoils ||
                   fc == FcWriteRegs)) begin
      r.error_code = ERR_UNSUPPORTED_FC;
    end else if (n < len_t'(4)) begin
      r.crc_status = CRC_INVALID;
      r.error_code = ERR_TRUNCATED;
    end else if (head.rx_crc != head.pcrc) begin
      r.crc_status = CRC_INVALID;
      r.error_code = ERR_CRC;
    end else begin
      r.crc_status = CRC_VALID;
      r.frame_role = head.master ? ROLE_REQUEST : ROLE_RESPONSE;
      if ((head.hdr[1] & ExcBit) != 8'h00) begin
        r.frame_role = ROLE_EXCEPTION;
        if (p != len_t'(3)) r.error_code = ERR_EXC_LEN;
        else r.exception_code = head.hdr[2];
      end else if (fc <= FcReadInput) begin
        rq = (p == len_t'(6));
        rs = (p >= len_t'(3)) && (len_t'(head.hdr[2]) == p - len_t'(3));
        if (rq != rs) r.frame_role = rq ? ROLE_REQUEST : ROLE_RESPONSE;
        if (r.frame_role == ROLE_REQUEST) begin
          if (p != len_t'(6)) r.error_code = ERR_READ_REQ_LEN;
          else begin
            r.field_set = FS_START_QTY; r.start_address = w2; r.count_or_value = w4;
          end
        end else begin
          if (p < len_t'(3)) r.error_code = ERR_READ_RESP_TRUNC;
          else if (p != len_t'(3) + len_t'(head.hdr[2])) r.error_code = ERR_READ_COUNT;
          else begin
            r.field_set = FS_COUNT; r.byte_count = head.hdr[2];
          end
        end
      end else if (fc == FcWriteCoil || fc == FcWriteReg) begin
        if (p != len_t'(6)) r.error_code = ERR_SINGLE_LEN;
        else begin
          r.field_set = FS_ADDR_VAL; r.start_address = w2; r.count_or_value = w4;
        end
      end else begin
        rq = (p >= len_t'(7)) && (len_t'(head.hdr[6]) == p - len_t'(7));
        rs = (p == len_t'(6));
        if (rq != rs) r.frame_role = rq ? ROLE_REQUEST : ROLE_RESPONSE;
        if (r.frame_role == ROLE_REQUEST) begin
          if (p < len_t'(7)) r.error_code = ERR_MULTI_REQ_TRUNC;
          else if (p != len_t'(7) + len_t'(head.hdr[6])) r.error_code = ERR_MULTI_COUNT;
          else begin
            r.field_set = FS_START_QTY_COUNT; r.start_address = w2;
            r.count_or_value = w4; r.byte_count = head.hdr[6];
          end
        end else begin
          if (p != len_t'(6)) r.error_code = ERR_MULTI_RESP_LEN;
          else begin
            r.field_set = FS_START_QTY; r.start_address = w2; r.count_or_value = w4;
          end
        end
      end
    end
  end

  assign pop = not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) rec <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid) else $error("record not presented");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(rec)))
    else $error("stalled record changed");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rec.error_code <= ERR_MULTI_RESP_LEN)) else $error("bad error code");
endmodule

[src/modbus_rtu_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_frame_decoder_core: modbus rtu frame decoder top level
//
//   channel  dir  payload
//   in_ch    in   data_byte, last_byte, from_master
//   out_ch   out  one decode record per frame
//
// one byte per cycle while the frame queue is not full; after the last byte the
// front snapshot enters the queue, then the registered decoder stage takes it.
// synchronous reset clears the collector, queue and output valid.
// in_ch stalls only while the two entry frame queue is full.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_decoder_core (
  input logic clk,
  input logic rst,
  mbrtu_in_if.sink    in_ch,
  mbrtu_out_if.source out_ch
);
  import mbrtu_pkg::*;

  in_item_t in_item;
  frame_t   push_frame;
  frame_t   head;
  rec_t     rec;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     not_empty;

  assign in_item = '{data_byte: in_ch.data_byte, last_byte: in_ch.last_byte,
                     from_master: in_ch.from_master};

  mbrtu_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
    .push, .push_frame, .q_full
  );

  mbrtu_queue u_queue (
    .clk, .rst, .push, .push_frame, .full(q_full), .pop, .not_empty, .head
  );

  mbrtu_back u_back (
    .clk, .rst, .not_empty, .head, .pop, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .rec
  );

  assign out_ch.station        = rec.station;
  assign out_ch.function_code  = rec.function_code;
  assign out_ch.frame_role     = rec.frame_role;
  assign out_ch.exception_code = rec.exception_code;
  assign out_ch.start_address  = rec.start_address;
  assign out_ch.count_or_value = rec.count_or_value;
  assign out_ch.byte_count     = rec.byte_count;
  assign out_ch.crc_status     = rec.crc_status;
  assign out_ch.error_code     = rec.error_code;
  assign out_ch.field_set      = rec.field_set;
endmodule
